### rtl/core/era_pkg.sv
// shared constants, types and tables for the euler rotation accumulator
// no dependencies
package era_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int ANGLE_W = 16;
  localparam int ENTRY_W = 18;
  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34; // cordic datapath width
  localparam int MW = 24; // multiplier operand width
  localparam int PW = 2 * MW; // product width
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032875);
  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = ENTRY_W'((1 <<< (FRAC_BITS + 1)) - 1);
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -ENTRY_W'(1 <<< (FRAC_BITS + 1));
  localparam logic signed [ENTRY_W-1:0] ONE_Q = ENTRY_W'(1 <<< FRAC_BITS);

  typedef logic signed [ENTRY_W-1:0] entry_t;

  function automatic logic signed [CW-1:0] atan_step(input logic [4:0] i);
    case (i)
      5'd0: atan_step = CW'(32'h20000000);
      5'd1: atan_step = CW'(32'h12E4051E);
      5'd2: atan_step = CW'(32'h09FB385B);
      5'd3: atan_step = CW'(32'h051111D4);
      5'd4: atan_step = CW'(32'h028B0D43);
      5'd5: atan_step = CW'(32'h0145D7E1);
      5'd6: atan_step = CW'(32'h00A2F61E);
      5'd7: atan_step = CW'(32'h00517C55);
      5'd8: atan_step = CW'(32'h0028BE53);
      5'd9: atan_step = CW'(32'h00145F2F);
      5'd10: atan_step = CW'(32'h000A2F98);
      5'd11: atan_step = CW'(32'h000517CC);
      5'd12: atan_step = CW'(32'h00028BE6);
      5'd13: atan_step = CW'(32'h000145F3);
      5'd14: atan_step = CW'(32'h0000A2FA);
      5'd15: atan_step = CW'(32'h0000517D);
      5'd16: atan_step = CW'(32'h000028BE);
      5'd17: atan_step = CW'(32'h0000145F);
      5'd18: atan_step = CW'(32'h00000A30);
      5'd19: atan_step = CW'(32'h00000518);
      5'd20: atan_step = CW'(32'h0000028C);
      5'd21: atan_step = CW'(32'h00000146);
      5'd22: atan_step = CW'(32'h000000A3);
      5'd23: atan_step = CW'(32'h00000051);
      default: atan_step = '0;
    endcase
  endfunction

  // saturate a wide sum into an entry
  function automatic entry_t clamp_entry(input logic signed [PW-1:0] v);
    if (v > PW'(ENTRY_MAX)) clamp_entry = ENTRY_MAX;
    else if (v < PW'(ENTRY_MIN)) clamp_entry = ENTRY_MIN;
    else clamp_entry = v[ENTRY_W-1:0];
  endfunction
endpackage

### rtl/core/era_cordic.sv
// iterative cordic: one micro-rotation per cycle, CORDIC_STEPS of them per angle
// depends on era_pkg
module era_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [era_pkg::ANGLE_W-1:0] angle,
  output logic done,
  output era_pkg::entry_t sin_q,
  output era_pkg::entry_t cos_q
);
  import era_pkg::*;

  logic signed [CW-1:0] x, y, z;
  logic [4:0] step;
  logic busy, flip;
  logic [31:0] turn, folded;
  logic signed [CW-1:0] xs, ys, xn, yn;

  assign turn = {angle[ANGLE_BITS-1:0], (32 - ANGLE_BITS)'(0)};
  assign folded = (turn >= 32'h40000000 && turn < 32'hC0000000) ?
                  turn - 32'h80000000 : turn;
  assign xs = x >>> step;
  assign ys = y >>> step;

  function automatic entry_t to_frac(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (r > CW'(ONE_Q)) to_frac = ONE_Q;
    else if (r < -CW'(ONE_Q)) to_frac = -ONE_Q;
    else to_frac = r[ENTRY_W-1:0];
  endfunction

  assign xn = flip ? -x : x;
  assign yn = flip ? -y : y;
  assign sin_q = to_frac(yn);
  assign cos_q = to_frac(xn);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else if (start) begin
      done <= 1'b0;
      busy <= 1'b1;
      step <= '0;
      x <= CORDIC_GAIN;
      y <= '0;
      z <= CW'(signed'(folded));
      flip <= (turn >= 32'h40000000 && turn < 32'hC0000000);
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_step(step);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_step(step);
      end
      done <= (step == 5'(CORDIC_STEPS - 1));
      if (step == 5'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
      step <= step + 5'd1;
    end else begin
      done <= 1'b0;
    end
  end
endmodule

### rtl/core/era_mac.sv
// shared rounding multiply-accumulate unit, one product per cycle
// depends on era_pkg
module era_mac (
  input  logic clk,
  input  logic en,
  input  logic clr,
  input  logic neg,
  input  logic signed [era_pkg::MW-1:0] a,
  input  logic signed [era_pkg::MW-1:0] b,
  output logic signed [era_pkg::PW-1:0] prod,
  output logic signed [era_pkg::PW-1:0] acc
);
  import era_pkg::*;

  logic signed [PW-1:0] p;
  assign p = (PW'(a) * PW'(b) + PW'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign prod = p;

  always_ff @(posedge clk) begin
    if (en) acc <= (clr ? '0 : acc) + (neg ? -p : p);
  end
endmodule

### rtl/core/euler_rotation_accumulate.sv
// euler rotation accumulator top: sequencer, cordic, mac and matrix state
// depends on era_pkg, era_cordic, era_mac
//
// channel | dir | fields
// s_axis  | in  | tdata: roll[15:0], pitch[31:16], yaw[47:32]
// m_axis  | out | tdata: nine 18-bit entries r0c0..r2c2, 162 bits in 168
//
// an item passes through an accept, three cordic runs, the R schedule, the mac
// products for R*M and a store and offer step; items are taken one at a time,
// since there is a single cordic unit and a single multiplier
// reset restores the identity matrix; s_axis_tready is low while busy
// and while a result waits on m_axis
module euler_rotation_accumulate (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [47:0] s_axis_tdata, // roll_angle, pitch_angle, yaw_angle
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [167:0] m_axis_tdata // entry_r0c0 .. entry_r2c2, zero pad
);
  import era_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_TRIG = 6'b000010, S_WAIT = 6'b000100,
    S_ROT = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state;
  logic [47:0] angles;
  logic [1:0] ang_idx;
  entry_t sv [3], cv [3];
  entry_t rot [9], mat [9], nxt [9];
  logic [4:0] cnt;
  logic [1:0] ri, rj, rr;
  logic signed [PW-1:0] tmp;

  logic cstart, cdone;
  entry_t csin, ccos;
  era_cordic u_cordic (.clk, .rst, .start(cstart), .angle(angles[15:0]),
                       .done(cdone), .sin_q(csin), .cos_q(ccos));

  logic men, mclr, mneg;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] mprod, macc;
  era_mac u_mac (.clk, .en(men), .clr(mclr), .neg(mneg), .a(ma), .b(mb),
                 .prod(mprod), .acc(macc));

  // R schedule: each step multiplies a by b; tmp holds double products
  entry_t sp, cp, st, ct, ss, cs;
  assign sp = sv[0]; assign cp = cv[0];
  assign st = sv[1]; assign ct = cv[1];
  assign ss = sv[2]; assign cs = cv[2];
  logic tmp_src, wr_rot;
  logic [3:0] rot_idx;

  always_comb begin
    ma = '0; mb = '0; men = 1'b0; mclr = 1'b0; mneg = 1'b0;
    tmp_src = 1'b0; wr_rot = 1'b0; rot_idx = '0;
    if (state == S_ROT) begin
      men = 1'b1;
      case (cnt)
        5'd0: begin ma = MW'(ct); mb = MW'(cs); mclr = 1'b1; wr_rot = 1'b1; rot_idx = 4'd0; end
        5'd1: begin ma = MW'(ct); mb = MW'(ss); mclr = 1'b1; wr_rot = 1'b1; rot_idx = 4'd3; end
        5'd2: begin ma = MW'(sp); mb = MW'(ct); mclr = 1'b1; wr_rot = 1'b1; rot_idx = 4'd7; end
        5'd3: begin ma = MW'(cp); mb = MW'(ct); mclr = 1'b1; wr_rot = 1'b1; rot_idx = 4'd8; end
        5'd4: begin ma = MW'(sp); mb = MW'(st); men = 1'b0; end
        5'd5: begin ma = MW'(cp); mb = MW'(ss); mclr = 1'b1; mneg = 1'b1; end
        5'd6: begin ma = MW'(tmp); mb = MW'(cs); wr_rot = 1'b1; rot_idx = 4'd1; end
        5'd7: begin ma = MW'(cp); mb = MW'(cs); mclr = 1'b1; end
        5'd8: begin ma = MW'(tmp); mb = MW'(ss); wr_rot = 1'b1; rot_idx = 4'd4; end
        5'd9: begin ma = MW'(cp); mb = MW'(st); men = 1'b0; end
        5'd10: begin ma = MW'(sp); mb = MW'(ss); mclr = 1'b1; end
        5'd11: begin ma = MW'(tmp); mb = MW'(cs); wr_rot = 1'b1; rot_idx = 4'd2; end
        5'd12: begin ma = MW'(sp); mb = MW'(cs); mclr = 1'b1; mneg = 1'b1; end
        5'd13: begin ma = MW'(tmp); mb = MW'(ss); wr_rot = 1'b1; rot_idx = 4'd5; end
        default: men = 1'b0;
      endcase
      tmp_src = (cnt == 5'd4) || (cnt == 5'd9);
    end else if (state == S_MUL) begin
      men = 1'b1;
      mclr = (rr == 2'd0);
      ma = MW'(rot[4'(ri) * 4'd3 + 4'(rr)]);
      mb = MW'(mat[4'(rr) * 4'd3 + 4'(rj)]);
    end
  end

  assign cstart = (state == S_TRIG);
  assign s_axis_tready = (state == S_IDLE);
  // offered only once the last entry has landed in mat
  assign m_axis_tvalid = (state == S_OUT) && (cnt == 5'd29);
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata[k*ENTRY_W +: ENTRY_W] = mat[k];
  end

  // pending write of previous mac result
  logic wr_pend, mul_pend;
  logic [3:0] wr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wr_pend <= 1'b0;
      mul_pend <= 1'b0;
      for (int k = 0; k < 9; k++) mat[k] <= (k % 4 == 0) ? ONE_Q : '0;
    end else begin
      wr_pend <= wr_rot;
      mul_pend <= (state == S_MUL) && (rr == 2'd2);
      if (wr_pend) rot[wr_idx] <= clamp_entry(macc);
      if (mul_pend) nxt[wr_idx] <= clamp_entry(macc);
      if (tmp_src) tmp <= mprod;
      if (wr_rot) wr_idx <= rot_idx;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          angles <= s_axis_tdata;
          ang_idx <= '0;
          state <= S_TRIG;
        end
        S_TRIG: state <= S_WAIT;
        S_WAIT: if (cdone) begin
          sv[ang_idx] <= csin;
          cv[ang_idx] <= ccos;
          angles <= {16'd0, angles[47:16]};
          ang_idx <= ang_idx + 2'd1;
          if (ang_idx == 2'd2) begin
            state <= S_ROT;
            cnt <= '0;
          end else state <= S_TRIG;
        end
        S_ROT: begin
          if (cnt == 5'd15) begin
            rot[6] <= -st;
            state <= S_MUL;
            ri <= '0; rj <= '0; rr <= '0;
            cnt <= '0;
          end else cnt <= cnt + 5'd1;
        end
        S_MUL: begin
          if (rr == 2'd2) begin
            rr <= '0;
            wr_idx <= 4'(ri) * 4'd3 + 4'(rj);
            if (rj == 2'd2) begin
              rj <= '0;
              if (ri == 2'd2) state <= S_OUT;
              ri <= ri + 2'd1;
            end else rj <= rj + 2'd1;
          end else rr <= rr + 2'd1;
          cnt <= cnt + 5'd1;
        end
        S_OUT: begin
          // 27: last entry lands in nxt, 28: copy to mat, 29: offer
          if (cnt == 5'd27) cnt <= 5'd28;
          else if (cnt == 5'd28) begin
            mat <= nxt;
            cnt <= 5'd29;
          end else if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
